[design/yrgb_pkg.sv]
// Package with shared constants, register codes and types of the YUY2 to RGB24 converter.
package yrgb_pkg;

    // Default frame size limits for the position counters.
    localparam int YRGB_MAX_WIDTH  = 2048;
    localparam int YRGB_MAX_HEIGHT = 2048;

    // Configuration register indexes.
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_FLIP_VERTICAL = 2'd2;

    // Register reset values.
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic        FLIP_RST         = 1'b0;

    // Q16 color coefficients, rounded to nearest.
    localparam logic signed [17:0] COEF_R_U = -18'sd61;
    localparam logic signed [17:0] COEF_R_V = 18'sd91861;
    localparam logic signed [17:0] COEF_G_U = -18'sd22524;
    localparam logic signed [17:0] COEF_G_V = -18'sd46804;
    localparam logic signed [17:0] COEF_B_U = 18'sd116140;
    localparam logic signed [17:0] COEF_B_V = 18'sd65;

    // Width of the Q16 sums: luma times 65536 plus two products.
    localparam int ACC_W = 27;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

[design/yrgb_intf.sv]
// Channel interfaces: YUY2 input, RGB output and configuration write.
interface yrgb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    input ready);
    modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                    output ready);
endinterface

interface yrgb_rgb_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_first;
    logic [7:0]  green_first;
    logic [7:0]  blue_first;
    logic [7:0]  red_second;
    logic [7:0]  green_second;
    logic [7:0]  blue_second;
    logic [10:0] pixel_column;
    logic [10:0] pixel_row;
    logic        frame_end;

    modport source (output valid, red_first, green_first, blue_first, red_second,
                    green_second, blue_second, pixel_column, pixel_row, frame_end,
                    input ready);
    modport sink   (input valid, red_first, green_first, blue_first, red_second,
                    green_second, blue_second, pixel_column, pixel_row, frame_end,
                    output ready);
endinterface

interface yrgb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [11:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[design/yuy2_to_rgb24_with_vertical_flip_top.sv]
// Top level of the YUY2 to RGB24 converter with row position and vertical flip.
//
//  Channel  Dir  Carries
//  i_pix    in   one YUY2 macropixel (Y0, U, Y1, V) per transaction
//  o_rgb    out  two RGB pixels, column, row and frame end per transaction
//  i_cfg    in   register index and data, one register write per transaction
//
// One macropixel is accepted every cycle while o_rgb is not stalled; its result
// passes through the input register, then conversion into the result register.
// Stalls on o_rgb fill the two stages and then hold i_pix.ready low.
// Reset is synchronous: it clears the counters and stage valids and loads the config registers.
// i_cfg is always ready; writes take effect on the next transaction.
module yuy2_to_rgb24_with_vertical_flip_top #(
    parameter int MAX_WIDTH  = yrgb_pkg::YRGB_MAX_WIDTH,
    parameter int MAX_HEIGHT = yrgb_pkg::YRGB_MAX_HEIGHT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    yrgb_pix_if.sink        i_pix,
    yrgb_rgb_if.source      o_rgb,
    yrgb_cfg_if.sink        i_cfg
);
    import yrgb_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMPW = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int CMPH = (RW + 1 > 12) ? RW + 1 : 12;

    // Configuration registers.
    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic        r_flip;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_flip         <= FLIP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_FRAME_WIDTH:   r_frame_width  <= i_cfg.wdata;
                REG_FRAME_HEIGHT:  r_frame_height <= i_cfg.wdata;
                REG_FLIP_VERTICAL: r_flip         <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // Position counters and the geometry of the pair being accepted.
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic [CMPW-1:0] width_eff;
    logic [CMPW-1:0] col_next;
    logic [CMPH-1:0] height_cap;
    logic [CMPH-1:0] height_eff;
    logic [CMPH-1:0] row_ext;
    logic [CMPH-1:0] row_inc;
    logic [CMPH-1:0] row_out;
    logic            row_end;
    logic            last_row;

    always_comb begin
        width_eff = (CMPW'(r_frame_width) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH)
                                                               : CMPW'(r_frame_width);
        col_next  = CMPW'(r_col) + CMPW'(2);
        row_end   = (col_next >= width_eff);

        height_cap = (CMPH'(r_frame_height) > CMPH'(MAX_HEIGHT)) ? CMPH'(MAX_HEIGHT)
                                                                  : CMPH'(r_frame_height);
        // A height of zero behaves as a single row.
        height_eff = (height_cap == '0) ? CMPH'(1) : height_cap;
        row_ext    = CMPH'(r_row);
        row_inc    = row_ext + CMPH'(1);
        last_row   = (row_inc >= height_eff);

        if (r_flip) begin
            row_out = (row_ext < height_eff) ? (height_eff - row_inc) : '0;
        end else begin
            row_out = row_ext;
        end

        if (row_end) begin
            n_col = '0;
            n_row = last_row ? '0 : row_inc[RW-1:0];
        end else begin
            n_col = col_next[CW-1:0];
            n_row = r_row;
        end
    end

    // Pipeline handshake.
    logic r_s1_valid;
    logic r_s2_valid;
    logic s1_ready;
    logic s2_ready;
    logic in_accept;

    assign s2_ready    = !r_s2_valid || o_rgb.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;
    assign in_accept   = i_pix.valid && s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Input register.
    logic [7:0]  r_s1_y0;
    logic [7:0]  r_s1_u;
    logic [7:0]  r_s1_y1;
    logic [7:0]  r_s1_v;
    logic [10:0] r_s1_col;
    logic [10:0] r_s1_row;
    logic        r_s1_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_y0   <= i_pix.luma_first;
            r_s1_u    <= i_pix.chroma_blue;
            r_s1_y1   <= i_pix.luma_second;
            r_s1_v    <= i_pix.chroma_red;
            r_s1_col  <= col_next[10:0] - 11'd2;
            r_s1_row  <= row_out[10:0];
            r_s1_fend <= row_end && last_row;
        end
    end

    // Flipping the top bit turns the offset-128 chroma into a signed difference.
    logic signed [7:0] du;
    logic signed [7:0] dv;
    t_rgb              px_first;
    t_rgb              px_second;

    assign du = $signed({~r_s1_u[7], r_s1_u[6:0]});
    assign dv = $signed({~r_s1_v[7], r_s1_v[6:0]});

    yrgb_pixel u_pixel_first (
        .i_luma (r_s1_y0),
        .i_du   (du),
        .i_dv   (dv),
        .o_rgb  (px_first)
    );

    yrgb_pixel u_pixel_second (
        .i_luma (r_s1_y1),
        .i_du   (du),
        .i_dv   (dv),
        .o_rgb  (px_second)
    );

    // Result register.
    t_rgb        r_s2_first;
    t_rgb        r_s2_second;
    logic [10:0] r_s2_col;
    logic [10:0] r_s2_row;
    logic        r_s2_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_ready) begin
            r_s2_first  <= px_first;
            r_s2_second <= px_second;
            r_s2_col    <= r_s1_col;
            r_s2_row    <= r_s1_row;
            r_s2_fend   <= r_s1_fend;
        end
    end

    assign o_rgb.valid        = r_s2_valid;
    assign o_rgb.red_first    = r_s2_first.red;
    assign o_rgb.green_first  = r_s2_first.green;
    assign o_rgb.blue_first   = r_s2_first.blue;
    assign o_rgb.red_second   = r_s2_second.red;
    assign o_rgb.green_second = r_s2_second.green;
    assign o_rgb.blue_second  = r_s2_second.blue;
    assign o_rgb.pixel_column = r_s2_col;
    assign o_rgb.pixel_row    = r_s2_row;
    assign o_rgb.frame_end    = r_s2_fend;

endmodule

[design/yrgb_pixel.sv]
// Converts one pixel from luma and shared chroma differences to clamped RGB.
module yrgb_pixel (
    input  logic [7:0]        i_luma,
    input  logic signed [7:0] i_du,
    input  logic signed [7:0] i_dv,
    output yrgb_pkg::t_rgb    o_rgb
);
    import yrgb_pkg::*;

    function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_W-1]) begin
            res = 8'd0;
        end else if (acc[ACC_W-2:16] > (ACC_W-17)'(255)) begin
            res = 8'd255;
        end else begin
            res = acc[23:16];
        end
        return res;
    endfunction

    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] sum_r;
    logic signed [ACC_W-1:0] sum_g;
    logic signed [ACC_W-1:0] sum_b;

    assign base  = $signed({3'b000, i_luma, 16'h0000});
    assign sum_r = base + COEF_R_U * i_du + COEF_R_V * i_dv;
    assign sum_g = base + COEF_G_U * i_du + COEF_G_V * i_dv;
    assign sum_b = base + COEF_B_U * i_du + COEF_B_V * i_dv;

    assign o_rgb.red   = to_byte(sum_r);
    assign o_rgb.green = to_byte(sum_g);
    assign o_rgb.blue  = to_byte(sum_b);

endmodule

[design/yrgb_checker.sv]
// Port-level checker for the converter top level, with its bind statement.
module yrgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_out_rgb,
    input logic [10:0] i_out_column,
    input logic [10:0] i_out_row,
    input logic        i_out_frame_end
);
    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic       r_after_end;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_acc && !out_acc) begin
            n_pending = r_pending + 2'd1;
        end else if (!in_acc && out_acc) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 2'd0;
            r_after_end <= 1'b0;
        end else begin
            r_pending <= n_pending;
            if (out_acc) begin
                r_after_end <= i_out_frame_end;
            end
        end
    end

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_rgb)
            && $stable(i_out_column) && $stable(i_out_row) && $stable(i_out_frame_end))
        else $error("stalled result changed");

    // Every result comes from an accepted macropixel, and at most two are in flight.
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || r_pending != 2'd0) && (r_pending != 2'd3))
        else $error("result count does not match accepted macropixels");

    // Pairs always start on an even column.
    a_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_column[0])
        else $error("odd pixel column");

    // The pair after a frame end starts a new row.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_after_end |-> i_out_column == 11'd0)
        else $error("column not reset after frame end");

endmodule

bind yuy2_to_rgb24_with_vertical_flip_top yrgb_checker u_yrgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_rgb.valid),
    .i_out_ready     (o_rgb.ready),
    .i_out_rgb       ({o_rgb.red_first, o_rgb.green_first, o_rgb.blue_first,
                       o_rgb.red_second, o_rgb.green_second, o_rgb.blue_second}),
    .i_out_column    (o_rgb.pixel_column),
    .i_out_row       (o_rgb.pixel_row),
    .i_out_frame_end (o_rgb.frame_end)
);
